// ----- hdl/srde_pkg.sv -----
package srde_pkg;

    localparam int VALUE_BITS = 64;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int PROD_W     = VALUE_BITS + RADIX_W;
    localparam int POW_DEPTH  = 41;
    localparam int IDX_W      = 6;
    localparam int UPC_W      = 4;
    localparam int SHIFT_W    = 3;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd3;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

    // Datapath operations.
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_SIGN  = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_CMP   = 3'd4;
    localparam logic [2:0] OP_DIVB  = 3'd5;
    localparam logic [2:0] OP_EMIT  = 3'd6;
    localparam logic [2:0] OP_LOADP = 3'd7;

    // Sequencing codes.
    localparam logic [2:0] JC_NEXT    = 3'd0;
    localparam logic [2:0] JC_ALWAYS  = 3'd1;
    localparam logic [2:0] JC_IF_LE   = 3'd2;
    localparam logic [2:0] JC_IF_KZ   = 3'd3;
    localparam logic [2:0] JC_WAIT_IN = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [2:0]         jc;
        logic [UPC_W-1:0]   tgt;
        logic [SHIFT_W-1:0] shift;
    } uword_t;

    typedef struct packed {
        logic               go;
        logic [2:0]         op;
        logic [SHIFT_W-1:0] shift;
    } ctl_t;

    typedef struct packed {
        logic le;
        logic k_zero;
        logic out_busy;
    } stat_t;

    // Microprogram. Steps 4 to 9 form a restoring division with a six-bit
    // quotient, one quotient bit per step.
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            4'd0:    w = '{OP_LOAD,  JC_WAIT_IN, 4'd0, 3'd0};
            4'd1:    w = '{OP_SIGN,  JC_NEXT,    4'd0, 3'd0};
            4'd2:    w = '{OP_MUL,   JC_NEXT,    4'd0, 3'd0};
            4'd3:    w = '{OP_CMP,   JC_IF_LE,   4'd2, 3'd0};
            4'd4:    w = '{OP_DIVB,  JC_NEXT,    4'd0, 3'd5};
            4'd5:    w = '{OP_DIVB,  JC_NEXT,    4'd0, 3'd4};
            4'd6:    w = '{OP_DIVB,  JC_NEXT,    4'd0, 3'd3};
            4'd7:    w = '{OP_DIVB,  JC_NEXT,    4'd0, 3'd2};
            4'd8:    w = '{OP_DIVB,  JC_NEXT,    4'd0, 3'd1};
            4'd9:    w = '{OP_DIVB,  JC_NEXT,    4'd0, 3'd0};
            4'd10:   w = '{OP_EMIT,  JC_IF_KZ,   4'd0, 3'd0};
            4'd11:   w = '{OP_LOADP, JC_ALWAYS,  4'd4, 3'd0};
            default: w = '{OP_NOP,   JC_ALWAYS,  4'd0, 3'd0};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

// ----- hdl/srde_seq.sv -----
module srde_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  srde_pkg::stat_t stat,
    output srde_pkg::ctl_t  ctl
);

    logic [srde_pkg::UPC_W-1:0] upc_reg;
    logic [srde_pkg::UPC_W-1:0] upc_next;
    logic [srde_pkg::UPC_W-1:0] upc_inc;
    srde_pkg::uword_t           uw;
    logic                       stall;

    assign uw      = srde_pkg::ucode(upc_reg);
    assign upc_inc = upc_reg + 1'b1;

    // A step holds while it waits for a request or for room in the output register.
    assign stall = ((uw.jc == srde_pkg::JC_WAIT_IN) && !s_tvalid) ||
                   (((uw.op == srde_pkg::OP_SIGN) || (uw.op == srde_pkg::OP_EMIT)) &&
                    stat.out_busy);

    assign s_tready  = (uw.op == srde_pkg::OP_LOAD);
    assign ctl.go    = !stall;
    assign ctl.op    = uw.op;
    assign ctl.shift = uw.shift;

    always_comb begin
        upc_next = upc_reg;
        if (!stall) begin
            unique case (uw.jc)
                srde_pkg::JC_NEXT:    upc_next = upc_inc;
                srde_pkg::JC_ALWAYS:  upc_next = uw.tgt;
                srde_pkg::JC_IF_LE:   upc_next = stat.le ? uw.tgt : upc_inc;
                srde_pkg::JC_IF_KZ:   upc_next = stat.k_zero ? uw.tgt : upc_inc;
                srde_pkg::JC_WAIT_IN: upc_next = upc_inc;
                default:              upc_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= '0;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- hdl/srde_dpath.sv -----
module srde_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [srde_pkg::VALUE_BITS-1:0]   in_value,
    input  logic [srde_pkg::RADIX_W-1:0]      in_radix,
    input  srde_pkg::ctl_t                    ctl,
    output srde_pkg::stat_t                   stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [srde_pkg::CHAR_W-1:0]       out_char,
    output logic                              out_last
);

    logic [srde_pkg::VALUE_BITS-1:0] mag_reg;
    logic [srde_pkg::VALUE_BITS-1:0] pow_reg;
    logic [srde_pkg::PROD_W-1:0]     prod_reg;
    logic [srde_pkg::RADIX_W-1:0]    radix_reg;
    logic [srde_pkg::RADIX_W-1:0]    dig_reg;
    logic [srde_pkg::IDX_W-1:0]      k_reg;
    logic                            neg_reg;
    logic [srde_pkg::VALUE_BITS-1:0] rd_reg;
    logic [srde_pkg::CHAR_W-1:0]     char_reg;
    logic                            last_reg;
    logic                            valid_reg;

    logic [srde_pkg::VALUE_BITS-1:0] pow_mem [srde_pkg::POW_DEPTH];

    logic [srde_pkg::PROD_W-1:0]     mag_ext;
    logic [srde_pkg::PROD_W-1:0]     trial;
    logic                            trial_fits;
    logic [srde_pkg::RADIX_W-1:0]    radix_clamped;
    logic                            in_neg;
    logic                            mem_we;
    logic [srde_pkg::IDX_W-1:0]      mem_wa;
    logic [srde_pkg::VALUE_BITS-1:0] mem_wd;
    logic                            do_emit;

    assign mag_ext    = srde_pkg::PROD_W'(mag_reg);
    assign trial      = srde_pkg::PROD_W'(pow_reg) << ctl.shift;
    assign trial_fits = (trial <= mag_ext);
    assign in_neg     = in_value[srde_pkg::VALUE_BITS-1];

    always_comb begin
        radix_clamped = in_radix;
        if (in_radix < srde_pkg::RADIX_MIN) begin
            radix_clamped = srde_pkg::RADIX_MIN;
        end else if (in_radix > srde_pkg::RADIX_MAX) begin
            radix_clamped = srde_pkg::RADIX_MAX;
        end
    end

    assign stat.le       = (prod_reg <= mag_ext);
    assign stat.k_zero   = (k_reg == '0);
    assign stat.out_busy = valid_reg && !out_ready;

    // Power table: entry k holds radix**k, written while scanning upward.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = srde_pkg::VALUE_BITS'(1);
        if (ctl.go && (ctl.op == srde_pkg::OP_LOAD)) begin
            mem_we = 1'b1;
        end else if (ctl.go && (ctl.op == srde_pkg::OP_CMP) && stat.le) begin
            mem_we = 1'b1;
            mem_wa = k_reg + 1'b1;
            mem_wd = prod_reg[srde_pkg::VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pow_mem[mem_wa] <= mem_wd;
        end
        if (ctl.go && (ctl.op == srde_pkg::OP_EMIT) && !stat.k_zero) begin
            rd_reg <= pow_mem[k_reg - 1'b1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.go) begin
            case (ctl.op)
                srde_pkg::OP_LOAD: begin
                    mag_reg   <= in_neg ? (~in_value + 1'b1) : in_value;
                    neg_reg   <= in_neg;
                    radix_reg <= radix_clamped;
                    pow_reg   <= srde_pkg::VALUE_BITS'(1);
                    k_reg     <= '0;
                    dig_reg   <= '0;
                end
                srde_pkg::OP_MUL: begin
                    prod_reg <= srde_pkg::PROD_W'(pow_reg) * srde_pkg::PROD_W'(radix_reg);
                end
                srde_pkg::OP_CMP: begin
                    if (stat.le) begin
                        pow_reg <= prod_reg[srde_pkg::VALUE_BITS-1:0];
                        k_reg   <= k_reg + 1'b1;
                    end
                    dig_reg <= '0;
                end
                srde_pkg::OP_DIVB: begin
                    if (trial_fits) begin
                        mag_reg            <= mag_reg - trial[srde_pkg::VALUE_BITS-1:0];
                        dig_reg[ctl.shift] <= 1'b1;
                    end
                end
                srde_pkg::OP_EMIT: begin
                    if (!stat.k_zero) begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                srde_pkg::OP_LOADP: begin
                    pow_reg <= rd_reg;
                    dig_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign do_emit = ctl.go && (((ctl.op == srde_pkg::OP_SIGN) && neg_reg) ||
                                (ctl.op == srde_pkg::OP_EMIT));

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            if (ctl.op == srde_pkg::OP_SIGN) begin
                char_reg <= srde_pkg::ASCII_MINUS;
                last_reg <= 1'b0;
            end else begin
                char_reg <= srde_pkg::digit_ascii(dig_reg);
                last_reg <= stat.k_zero;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (do_emit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// ----- hdl/signed_radix_digit_emitter_top.sv -----
// Output order: the sign, when there is one, comes from the sign step that follows the
// taken request and waits in the output register; each digit comes from an emit step
// after its six division steps. A held output register stalls those steps.
// A new request is taken only after the last digit of the number before it is emitted.
// A number has 40 digits at most; the microprogram spends two steps per power in the scan.
// Reset: aresetn is synchronous and active low; it returns the sequencer to its
// idle step and empties the output register. The power table needs no clearing.
module signed_radix_digit_emitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input request. s_tdata fields from bit 0 up: value[63:0], radix[69:64], zero pad.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    // Result requests, one character each. m_tdata fields from bit 0 up:
    // digit_char[6:0], zero pad.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    // Control from the sequencer to the datapath, and status flags back.
    srde_pkg::ctl_t                ctl;
    srde_pkg::stat_t               stat;
    logic [srde_pkg::CHAR_W-1:0]   out_char;

    // The sequencer steps through a twelve-word microprogram: take a request, emit the
    // sign, scan the powers of the radix upward, then peel off one digit per pass of
    // a six-step restoring division, walking back down the stored powers.
    srde_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // The datapath holds the magnitude, the current power, the power table and the
    // output register, so a finished character waits there while work goes on.
    // The radix always sits at bits 69:64, whatever part of the value field is used.
    srde_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_value  (s_tdata[srde_pkg::VALUE_BITS-1:0]),
        .in_radix  (s_tdata[69:64]),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    // The character sits in the low seven bits; the top bit of the byte is padding.
    assign m_tdata = {1'b0, out_char};

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // The run is stopped by force if it lasts longer than this many clock cycles.
    // The estimate for the slowest correct run assumes that
    // every request yields 41 characters and every character waits out the
    // longest stall, and the limit gives a wide margin over it.
    localparam int CYCLE_LIMIT  = 6_000_000;
    // Quiet cycles after the last expected character. Any stray character
    // that comes out in this window is flagged by the monitor.
    localparam int DRAIN_CYCLES = 500;
    // The long receiver hold-off starts once this many requests have gone in.
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 1500;
    localparam int RANDOM_REQS  = 350;
    localparam int MAX_REPORTS  = 10;

    localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VALUE_MIN = 64'h8000_0000_0000_0000;

    // One expected output character and its end-of-number mark.
    typedef struct packed {
        logic [srde_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } char_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // Characters still owed by the block, oldest first.
    char_t       expected_chars[$];
    // For each request offered to the block, the literal text it must produce.
    // An empty string means that the text comes from the digit predictor.
    string       pending_text[$];

    // The directed table. Each row is one request.
    logic [63:0] dir_value[$];
    logic [5:0]  dir_radix[$];
    string       dir_text[$];

    int          cycle_count    = 0;
    int          req_count      = 0;
    int          fail_count     = 0;
    int          mismatch_count = 0;
    int          tx_burst       = 0;
    int          rx_burst       = 0;
    bit          held_off       = 1'b0;

    signed_radix_digit_emitter_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The clock has a period of 10 ns.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Queues the characters that one request must produce. The value is taken
    // as two's complement within VALUE_BITS. The radix is clamped to the
    // supported range. The scan finds the largest power of the radix that is
    // not above the magnitude. Each digit is then split off by a division.
    function automatic void predict_digits(input logic [63:0] raw, input logic [5:0] rad_in);
        logic [63:0] mask;
        logic [63:0] val;
        logic [63:0] rad;
        logic [63:0] mag;
        logic [63:0] pw;
        logic [63:0] d;
        logic [srde_pkg::CHAR_W-1:0] ch;
        bit          neg;
        mask = (srde_pkg::VALUE_BITS >= 64) ? '1
             : ((64'd1 << srde_pkg::VALUE_BITS) - 64'd1);
        val  = raw & mask;
        rad  = 64'(rad_in);
        if (rad < 64'(srde_pkg::RADIX_MIN)) begin
            rad = 64'(srde_pkg::RADIX_MIN);
        end
        if (rad > 64'(srde_pkg::RADIX_MAX)) begin
            rad = 64'(srde_pkg::RADIX_MAX);
        end
        neg = val[srde_pkg::VALUE_BITS-1];
        // The most negative value negates onto itself. As an unsigned number
        // it is still the exact magnitude.
        mag = neg ? ((~val + 64'd1) & mask) : val;
        if (neg) begin
            expected_chars.push_back(char_t'{srde_pkg::ASCII_MINUS, 1'b0});
        end
        pw = 64'd1;
        while (pw <= mag / rad) begin
            pw = pw * rad;
        end
        while (pw != 64'd0) begin
            d   = mag / pw;
            mag = mag - d * pw;
            pw  = pw / rad;
            if (d < 64'(srde_pkg::DIGIT_TEN)) begin
                ch = srde_pkg::ASCII_ZERO + srde_pkg::CHAR_W'(d);
            end else begin
                ch = srde_pkg::ASCII_A + srde_pkg::CHAR_W'(d - 64'(srde_pkg::DIGIT_TEN));
            end
            expected_chars.push_back(char_t'{ch, pw == 64'd0});
        end
    endfunction

    // Queues a literal expected text. The final character carries the mark.
    function automatic void expect_text(input string txt);
        byte b;
        for (int i = 0; i < txt.len(); i++) begin
            b = txt[i];
            expected_chars.push_back(char_t'{b[srde_pkg::CHAR_W-1:0], i == txt.len() - 1});
        end
    endfunction

    // Picks an idle gap in cycles. Most gaps are short and a few are long.
    // Now and then a run of zero gaps gives a stretch of full speed.
    function automatic int pick_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 30);
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(0, 3);
    endfunction

    // Returns a random value. The spread covers small and mid-sized numbers
    // and full 64-bit patterns. It also covers values right at a power of the
    // radix, where the scan either stops or takes one more step, and the
    // extremes of the signed range.
    function automatic logic [63:0] random_value(input logic [5:0] rad_in);
        logic [63:0] v;
        logic [63:0] rad;
        int          kind;
        int          steps;
        kind = $urandom_range(0, 9);
        rad  = (rad_in < srde_pkg::RADIX_MIN) ? 64'(srde_pkg::RADIX_MIN)
             : (rad_in > srde_pkg::RADIX_MAX) ? 64'(srde_pkg::RADIX_MAX) : 64'(rad_in);
        if (kind <= 2) begin
            v = 64'($urandom_range(0, 2000));
        end else if (kind <= 4) begin
            v = {$urandom, $urandom};
        end else if (kind <= 6) begin
            v = 64'd1;
            steps = $urandom_range(1, 40);
            for (int j = 0; j < steps; j++) begin
                if (v <= 64'hFFFF_FFFF_FFFF_FFFF / rad) begin
                    v = v * rad;
                end
            end
            v = v + 64'($urandom_range(0, 2)) - 64'd1;
        end else if (kind == 7) begin
            case ($urandom_range(0, 4))
                0:       v = VALUE_MAX;
                1:       v = VALUE_MIN;
                2:       v = VALUE_MIN + 64'd1;
                3:       v = '1;
                default: v = '0;
            endcase
        end else begin
            v = 64'($urandom);
        end
        // Negate about half of the values that were not picked for their
        // exact bit pattern.
        if (kind != 7 && kind != 3 && kind != 4 && $urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    function automatic void add_row(input logic [63:0] v, input logic [5:0] r,
                                    input string txt);
        dir_value.push_back(v);
        dir_radix.push_back(r);
        dir_text.push_back(txt);
    endfunction

    // Offers one request after a random gap and holds it until the block takes
    // it. When the gap is zero, valid stays high from one request to the next.
    task automatic send_request(input logic [63:0] v, input logic [5:0] r,
                                input string txt);
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r, v};
        pending_text.push_back(txt);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic report_fail(input string what, input char_t want, input logic [7:0] got,
                               input logic got_last);
        if (mismatch_count < MAX_REPORTS) begin
            $display("%0s at cycle %0d: expected char 0x%02h last %0b, got 0x%02h last %0b",
                     what, cycle_count, want.ch, want.last, got, got_last);
        end
        mismatch_count++;
        fail_count++;
    endtask

    // The monitor samples both handshakes at the clock edge. The testbench
    // drives its signals with nonblocking assignments, so every value that is
    // read here is the one that was present at the edge. An accepted request
    // queues the characters it must produce. An accepted character is checked
    // against the oldest one that is still owed.
    always @(posedge aclk) begin : monitor
        string txt;
        char_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                txt = pending_text.pop_front();
                if (txt.len() == 0) begin
                    predict_digits(s_tdata[63:0], s_tdata[69:64]);
                end else begin
                    expect_text(txt);
                end
                req_count++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_fail("Unexpected character", char_t'('0), m_tdata, m_tlast);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.last) begin
                        report_fail("Mismatch", want, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    // The receiver stalls at random. Once enough requests have gone in, it
    // holds off for a long stretch while the sender goes on offering
    // requests. This fills the block and makes it stall its input.
    initial begin : receiver
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held_off && req_count >= HOLD_AFTER) begin
                gap      = HOLD_CYCLES;
                held_off = 1'b1;
            end else begin
                gap = pick_gap(rx_burst);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Watchdog. If the run hangs, it stops here with a failure.
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic [5:0]  r;
        logic [63:0] v;

        // Directed requests. A row holds its expected text where the text is
        // plain to see. Rows with an empty text are checked by the predictor.
        add_row(64'd0,               6'd10, "0");
        add_row(64'd0,               6'd0,  "0");     // radix below range, clamped to 3
        add_row(64'd2,               6'd0,  "2");
        add_row(64'd3,               6'd1,  "10");
        add_row(64'd1,               6'd2,  "1");
        add_row(64'd35,              6'd36, "Z");
        add_row(64'd35,              6'd63, "Z");     // radix above range, clamped to 36
        add_row(64'd36,              6'd37, "10");
        add_row(64'd9,               6'd10, "9");
        add_row(64'd10,              6'd10, "10");
        add_row(64'd8,               6'd3,  "22");
        add_row(64'd255,             6'd16, "FF");
        add_row(64'd1295,            6'd36, "ZZ");
        add_row(-64'd1,              6'd10, "-1");
        add_row('1,                  6'd36, "-1");
        add_row(-64'd10,             6'd16, "-A");
        add_row(-64'd36,             6'd36, "-10");
        add_row(VALUE_MAX,           6'd10, "9223372036854775807");
        add_row(VALUE_MIN,           6'd10, "-9223372036854775808");
        // The most negative value in radix 3 gives the longest output.
        add_row(VALUE_MIN,           6'd3,  "");
        add_row(VALUE_MAX,           6'd36, "");
        add_row(VALUE_MIN + 64'd1,   6'd7,  "");
        add_row(64'h5555_5555_5555_5555, 6'd37, "");
        add_row(64'hAAAA_AAAA_AAAA_AAAA, 6'd1,  "");

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < dir_value.size(); i++) begin
            send_request(dir_value[i], dir_radix[i], dir_text[i]);
        end

        // Random requests. Most use a radix inside the range, and some use
        // any 6-bit radix.
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                r = 6'($urandom_range(0, 63));
            end else begin
                r = 6'($urandom_range(srde_pkg::RADIX_MIN, srde_pkg::RADIX_MAX));
            end
            v = random_value(r);
            send_request(v, r, "");
        end
        s_tvalid <= 1'b0;

        // Wait until every request has been taken and every character has
        // come out. Then let the block sit idle so that stray output shows up.
        while (pending_text.size() != 0 || expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
